// ===== design/assert_macros.svh =====
// assertion macros of the basis evaluator, used by its asserting top level
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked on every rising edge outside reset
`define BBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== design/bbe_pkg.sv =====
// types, constants and helper functions of the b-spline basis evaluator
// no dependencies; used by bbe_term_unit, bbe_ctrl and the top level
`timescale 1ns / 1ps

package bbe_pkg;

  // field widths
  localparam int PARAM_W   = 23;
  localparam int INDEX_W   = 6;
  localparam int FRAC_BITS = 16;
  localparam int VALUE_W   = FRAC_BITS + 1;
  localparam int ORD_W     = 4;
  localparam int PTS_W     = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  // point count saturation
  localparam int MAX_POINTS = 64;

  // register reset values
  localparam logic [ORD_W-1:0] ORDER_RST  = 4'd4;
  localparam logic [PTS_W-1:0] POINTS_RST = 7'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPLINE_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 1'b1;

  // knot and fixed point widths
  localparam int KNOT_W = PTS_W;
  localparam int FX_W   = KNOT_W + FRAC_BITS;
  localparam int POS_W  = 8;
  localparam int DEN_W  = 4;
  localparam logic [VALUE_W-1:0] ONE_FX = VALUE_W'(1) << FRAC_BITS;

  // term unit widths: product, quotient, reciprocal
  localparam int PROD_W      = PARAM_W + VALUE_W;
  localparam int QUOT_W      = PROD_W - FRAC_BITS;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int QP_W        = QUOT_W + RECIP_W;

  typedef struct packed {
    logic [PARAM_W-1:0] param_value;
    logic [INDEX_W-1:0] basis_index;
  } bbe_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] basis_value;
    logic               index_error;
  } bbe_out_t;

  // effective configuration seen by the sequencer
  typedef struct packed {
    logic [ORD_W-1:0] order;
    logic [PTS_W-1:0] points;
  } bbe_cfg_t;

  // request to the shared term unit
  typedef struct packed {
    logic               valid;
    logic [PARAM_W-1:0] num;
    logic [VALUE_W-1:0] basis;
    logic [DEN_W-1:0]   den;
  } bbe_req_t;

  // response of the shared term unit
  typedef struct packed {
    logic              valid;
    logic [QUOT_W-1:0] quot;
  } bbe_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_TERM1,
    ST_WAIT1,
    ST_TERM2,
    ST_WAIT2,
    ST_NODE,
    ST_ALIGN
  } bbe_state_e;

  // ceil(2^RECIP_SHIFT / d), exact floor division for quotients below 2^QUOT_W
  function automatic logic [RECIP_W-1:0] recip(logic [DEN_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd1:    r = 29'd268435456;
      4'd2:    r = 29'd134217728;
      4'd3:    r = 29'd89478486;
      4'd4:    r = 29'd67108864;
      4'd5:    r = 29'd53687092;
      4'd6:    r = 29'd44739243;
      4'd7:    r = 29'd38347923;
      4'd8:    r = 29'd33554432;
      4'd9:    r = 29'd29826162;
      4'd10:   r = 29'd26843546;
      4'd11:   r = 29'd24403224;
      4'd12:   r = 29'd22369622;
      4'd13:   r = 29'd20648882;
      4'd14:   r = 29'd19173962;
      4'd15:   r = 29'd17895698;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamped uniform knot at position pos
  function automatic logic [KNOT_W-1:0] knot_at(logic [POS_W-1:0] pos,
                                                logic [ORD_W-1:0] k,
                                                logic [PTS_W-1:0] n);
    int v;
    int top;
    v   = int'(pos) - int'(k) + 1;
    top = int'(n) - int'(k) + 1;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return KNOT_W'(v);
  endfunction

endpackage

// ===== design/bbe_term_unit.sv =====
// shared term unit: product of parameter difference and basis value, then
// rounded division by the scaled knot difference via a reciprocal table
// depends on bbe_pkg
`timescale 1ns / 1ps

module bbe_term_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbe_pkg::bbe_req_t req_i,
  output bbe_pkg::bbe_rsp_t rsp_o
);

  logic                             v1_q, v2_q;
  logic [bbe_pkg::PROD_W-1:0]       prod_q, prod_d;
  logic [bbe_pkg::DEN_W-1:0]        den_q;
  logic [bbe_pkg::QP_W-1:0]         qprod_q, qprod_d;
  logic [bbe_pkg::PROD_W-1:0]       rnd_sum;
  logic [bbe_pkg::QUOT_W-1:0]       y_val;
  logic [bbe_pkg::RECIP_W-1:0]      rcp;

  // stage one: exact product
  assign prod_d = bbe_pkg::PROD_W'(req_i.num) * bbe_pkg::PROD_W'(req_i.basis);

  // stage two: add half the divisor, drop fraction bits, multiply by reciprocal
  always_comb begin
    rnd_sum = prod_q + (bbe_pkg::PROD_W'(den_q) << (bbe_pkg::FRAC_BITS - 1));
    y_val   = rnd_sum[bbe_pkg::PROD_W-1:bbe_pkg::FRAC_BITS];
    rcp     = bbe_pkg::recip(den_q);
    qprod_d = bbe_pkg::QP_W'(y_val) * bbe_pkg::QP_W'(rcp);
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    den_q   <= req_i.den;
    qprod_q <= qprod_d;
  end

  assign rsp_o.valid = v2_q;
  assign rsp_o.quot  = qprod_q[bbe_pkg::RECIP_SHIFT +: bbe_pkg::QUOT_W];

endmodule

// ===== design/bbe_ctrl.sv =====
// sequencer of the cox-de boor recurrence: basis slots, level and node
// counters, term issue to the shared unit; depends on bbe_pkg
`timescale 1ns / 1ps

module bbe_ctrl #(
  parameter int MAX_ORDER = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bbe_pkg::bbe_in_t  in_i,
  input  bbe_pkg::bbe_cfg_t cfg_i,
  output bbe_pkg::bbe_req_t req_o,
  input  bbe_pkg::bbe_rsp_t rsp_i,
  output logic              busy_o,
  output logic              result_stb_o,
  output bbe_pkg::bbe_out_t result_o
);

  localparam int SLOT_W = $clog2(MAX_ORDER);

  bbe_pkg::bbe_state_e              state_q, state_d;
  logic [bbe_pkg::PARAM_W-1:0]      u_q, u_d;
  logic [bbe_pkg::INDEX_W-1:0]      i_q, i_d;
  logic [bbe_pkg::ORD_W-1:0]        j_q, j_d;
  logic [bbe_pkg::ORD_W-1:0]        lvl_q, lvl_d;
  logic [SLOT_W-1:0]                rot_q, rot_d;
  logic [bbe_pkg::QUOT_W-1:0]       acc_q, acc_d;
  logic [bbe_pkg::VALUE_W-1:0]      slot_q [MAX_ORDER];
  logic [bbe_pkg::VALUE_W-1:0]      slot_d [MAX_ORDER];
  logic [bbe_pkg::VALUE_W-1:0]      init_v [MAX_ORDER];
  logic                             stb_q, stb_d;
  bbe_pkg::bbe_out_t                res_q, res_d;

  logic [bbe_pkg::ORD_W-1:0]        p_deg;
  logic                             idx_err;
  logic                             last_lvl, last_node;
  logic [bbe_pkg::POS_W-1:0]        pos_a, pos_aq, pos_a1, pos_aq1;
  logic [bbe_pkg::KNOT_W-1:0]       ta, taq, ta1, taq1;
  logic [bbe_pkg::FX_W-1:0]         fa, fq1;
  logic                             act1, act2;
  logic [bbe_pkg::QUOT_W:0]         node_sum;
  logic [bbe_pkg::VALUE_W-1:0]      node_val;
  logic [bbe_pkg::POS_W-1:0]        init_lo_pos, init_hi_pos;
  logic [bbe_pkg::FX_W-1:0]         init_lo, init_hi;

  // item decode: degree, index range, knots of the current node
  always_comb begin
    p_deg     = cfg_i.order - bbe_pkg::ORD_W'(1);
    idx_err   = {1'b0, i_q} >= cfg_i.points;
    last_lvl  = lvl_q == p_deg;
    last_node = j_q == (p_deg - lvl_q);
    pos_a     = bbe_pkg::POS_W'(i_q) + bbe_pkg::POS_W'(j_q);
    pos_aq    = pos_a + bbe_pkg::POS_W'(lvl_q);
    pos_a1    = pos_a + bbe_pkg::POS_W'(1);
    pos_aq1   = pos_aq + bbe_pkg::POS_W'(1);
    ta        = bbe_pkg::knot_at(pos_a, cfg_i.order, cfg_i.points);
    taq       = bbe_pkg::knot_at(pos_aq, cfg_i.order, cfg_i.points);
    ta1       = bbe_pkg::knot_at(pos_a1, cfg_i.order, cfg_i.points);
    taq1      = bbe_pkg::knot_at(pos_aq1, cfg_i.order, cfg_i.points);
    fa        = {ta, {bbe_pkg::FRAC_BITS{1'b0}}};
    fq1       = {taq1, {bbe_pkg::FRAC_BITS{1'b0}}};
    // a term is issued only when it can be nonzero
    act1      = (taq != ta) && (u_q >= fa) && (slot_q[0] != '0);
    act2      = (taq1 != ta1) && (fq1 >= u_q) && (slot_q[1] != '0);
    node_sum  = {1'b0, acc_q} + (rsp_i.valid ? {1'b0, rsp_i.quot} : '0);
    node_val  = (node_sum > (bbe_pkg::QUOT_W + 1)'(bbe_pkg::ONE_FX)) ?
                bbe_pkg::ONE_FX : node_sum[bbe_pkg::VALUE_W-1:0];
  end

  // degree-zero values: one half-open interval test per slot
  always_comb begin
    for (int s = 0; s < MAX_ORDER; s++) begin
      init_lo_pos = bbe_pkg::POS_W'(i_q) + bbe_pkg::POS_W'(s);
      init_hi_pos = init_lo_pos + bbe_pkg::POS_W'(1);
      init_lo = {bbe_pkg::knot_at(init_lo_pos, cfg_i.order, cfg_i.points),
                 {bbe_pkg::FRAC_BITS{1'b0}}};
      init_hi = {bbe_pkg::knot_at(init_hi_pos, cfg_i.order, cfg_i.points),
                 {bbe_pkg::FRAC_BITS{1'b0}}};
      init_v[s] = (s <= int'(p_deg) && u_q >= init_lo && u_q < init_hi) ?
                  bbe_pkg::ONE_FX : '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bbe_pkg::ST_IDLE: begin
        if (start_i) state_d = bbe_pkg::ST_INIT;
      end
      bbe_pkg::ST_INIT: begin
        if (idx_err || p_deg == '0) state_d = bbe_pkg::ST_IDLE;
        else state_d = bbe_pkg::ST_TERM1;
      end
      bbe_pkg::ST_TERM1: begin
        state_d = act1 ? bbe_pkg::ST_WAIT1 : bbe_pkg::ST_TERM2;
      end
      bbe_pkg::ST_WAIT1: state_d = bbe_pkg::ST_TERM2;
      bbe_pkg::ST_TERM2: begin
        state_d = act2 ? bbe_pkg::ST_WAIT2 : bbe_pkg::ST_NODE;
      end
      bbe_pkg::ST_WAIT2: state_d = bbe_pkg::ST_NODE;
      bbe_pkg::ST_NODE: begin
        if (last_lvl) state_d = bbe_pkg::ST_IDLE;
        else if (last_node) state_d = bbe_pkg::ST_ALIGN;
        else state_d = bbe_pkg::ST_TERM1;
      end
      bbe_pkg::ST_ALIGN: begin
        if (rot_q == SLOT_W'(1)) state_d = bbe_pkg::ST_TERM1;
      end
      default: state_d = bbe_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    u_d   = u_q;
    i_d   = i_q;
    j_d   = j_q;
    lvl_d = lvl_q;
    rot_d = rot_q;
    acc_d = acc_q;
    stb_d = 1'b0;
    res_d = res_q;
    req_o = '0;
    for (int s = 0; s < MAX_ORDER; s++) slot_d[s] = slot_q[s];
    case (state_q)
      bbe_pkg::ST_IDLE: begin
        if (start_i) begin
          u_d = in_i.param_value;
          i_d = in_i.basis_index;
        end
      end
      bbe_pkg::ST_INIT: begin
        for (int s = 0; s < MAX_ORDER; s++) slot_d[s] = init_v[s];
        j_d   = '0;
        lvl_d = bbe_pkg::ORD_W'(1);
        if (idx_err) begin
          stb_d = 1'b1;
          res_d = '{basis_value: '0, index_error: 1'b1};
        end else if (p_deg == '0) begin
          stb_d = 1'b1;
          res_d = '{basis_value: init_v[0], index_error: 1'b0};
        end
      end
      // left term: (u - t_a) * N(a) / (t_(a+q) - t_a)
      bbe_pkg::ST_TERM1: begin
        if (act1) begin
          req_o.valid = 1'b1;
          req_o.num   = u_q - fa;
          req_o.basis = slot_q[0];
          req_o.den   = bbe_pkg::DEN_W'(taq - ta);
        end
      end
      // right term: (t_(a+q+1) - u) * N(a+1) / (t_(a+q+1) - t_(a+1))
      bbe_pkg::ST_TERM2: begin
        acc_d = rsp_i.valid ? rsp_i.quot : '0;
        if (act2) begin
          req_o.valid = 1'b1;
          req_o.num   = fq1 - u_q;
          req_o.basis = slot_q[1];
          req_o.den   = bbe_pkg::DEN_W'(taq1 - ta1);
        end
      end
      // node done: shift slots down, new value enters at the top
      bbe_pkg::ST_NODE: begin
        for (int s = 0; s < MAX_ORDER - 1; s++) slot_d[s] = slot_q[s + 1];
        slot_d[MAX_ORDER-1] = node_val;
        j_d = j_q + bbe_pkg::ORD_W'(1);
        if (last_lvl) begin
          stb_d = 1'b1;
          res_d = '{basis_value: node_val, index_error: 1'b0};
        end else if (last_node) begin
          rot_d = SLOT_W'(MAX_ORDER - (int'(p_deg) - int'(lvl_q) + 1));
        end
      end
      // rotate the new level back to slot zero
      bbe_pkg::ST_ALIGN: begin
        for (int s = 0; s < MAX_ORDER - 1; s++) slot_d[s] = slot_q[s + 1];
        slot_d[MAX_ORDER-1] = slot_q[0];
        if (rot_q == SLOT_W'(1)) begin
          lvl_d = lvl_q + bbe_pkg::ORD_W'(1);
          j_d   = '0;
        end else begin
          rot_d = rot_q - SLOT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbe_pkg::ST_IDLE;
      stb_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      stb_q   <= stb_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    i_q   <= i_d;
    j_q   <= j_d;
    lvl_q <= lvl_d;
    rot_q <= rot_d;
    acc_q <= acc_d;
    res_q <= res_d;
    for (int s = 0; s < MAX_ORDER; s++) slot_q[s] <= slot_d[s];
  end

  assign busy_o       = state_q != bbe_pkg::ST_IDLE;
  assign result_stb_o = stb_q;
  assign result_o     = res_q;

endmodule

// ===== design/bspline_basis_eval_unit.sv =====
// top level of the b-spline basis evaluator: configuration registers,
// sequencer and shared term unit; depends on bbe_pkg, bbe_ctrl, bbe_term_unit
//
// usage:
//   input: drive in_i and raise start; the transaction is taken at a rising
//   edge with start high and busy low. busy stays high while the item runs.
//   output: result_o is valid for exactly one cycle with result_stb_o high;
//   the receiver cannot stall and must take it in that cycle.
//   configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 spline order, 1 point count) at once; write only while busy is low.
//   sequence: for an index error or order one the result is decided in the
//   init state and registered onto the strobe; otherwise, after the init
//   state, each node runs a left-term, a right-term and a node state, with a
//   wait state after each issued term. every term passes through the one
//   two-stage multiply and reciprocal unit, and the basis slots realign by
//   one rotation per cycle after each level below the top.
//   throughput: one item at a time; a new start may be taken in the strobe
//   cycle. reset returns to idle with order 4 and point count 8.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bspline_basis_eval_unit #(
  parameter int MAX_ORDER = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  bbe_pkg::bbe_in_t                in_i,
  output logic                            result_stb_o,
  output bbe_pkg::bbe_out_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bbe_pkg::CFG_W-1:0]       cfg_wdata_i
);

  logic [bbe_pkg::ORD_W-1:0] order_q;
  logic [bbe_pkg::PTS_W-1:0] points_q;
  logic [bbe_pkg::ORD_W-1:0] ord_eff;
  logic [bbe_pkg::PTS_W-1:0] pts_eff;
  bbe_pkg::bbe_cfg_t         cfg_eff;
  bbe_pkg::bbe_req_t         unit_req;
  bbe_pkg::bbe_rsp_t         unit_rsp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q  <= bbe_pkg::ORDER_RST;
      points_q <= bbe_pkg::POINTS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bbe_pkg::REG_SPLINE_ORDER: order_q  <= cfg_wdata_i[bbe_pkg::ORD_W-1:0];
        bbe_pkg::REG_POINT_COUNT:  points_q <= cfg_wdata_i[bbe_pkg::PTS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective order and point count after saturation
  always_comb begin
    ord_eff = order_q;
    if (ord_eff == '0) ord_eff = bbe_pkg::ORD_W'(1);
    if (int'(ord_eff) > MAX_ORDER) ord_eff = bbe_pkg::ORD_W'(MAX_ORDER);
    pts_eff = points_q;
    if (int'(pts_eff) > bbe_pkg::MAX_POINTS) pts_eff = bbe_pkg::PTS_W'(bbe_pkg::MAX_POINTS);
    if (pts_eff < bbe_pkg::PTS_W'(ord_eff)) pts_eff = bbe_pkg::PTS_W'(ord_eff);
    cfg_eff = '{order: ord_eff, points: pts_eff};
  end

  // recurrence sequencer
  bbe_ctrl #(
    .MAX_ORDER (MAX_ORDER)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .in_i         (in_i),
    .cfg_i        (cfg_eff),
    .req_o        (unit_req),
    .rsp_i        (unit_rsp),
    .busy_o       (busy),
    .result_stb_o (result_stb_o),
    .result_o     (result_o)
  );

  // shared multiply and divide unit
  bbe_term_unit u_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  // checks
  `BBE_ASSERT_IMP(a_done_strobes, $fell(busy), result_stb_o)
  `BBE_ASSERT_IMP(a_strobe_ends_item, result_stb_o, $past(busy))
  `BBE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `BBE_ASSERT_IMP(a_err_zero, result_stb_o && result_o.index_error, result_o.basis_value == '0)
  `BBE_ASSERT_IMP(a_value_le_one, result_stb_o, result_o.basis_value <= bbe_pkg::ONE_FX)

endmodule
